@@ rtl/glyph_rasterizer_4x5_top_assert.svh @@
// Assertion macros for the glyph rasterizer top level.
`ifndef GLYPH_RASTERIZER_4X5_TOP_ASSERT_SVH
`define GLYPH_RASTERIZER_4X5_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define GR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define GR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/gr4x5_pkg.sv @@
// Shared constants, types and font ROM for the glyph rasterizer.
`timescale 1ns / 1ps
package gr4x5_pkg;

  // glyph geometry
  localparam int GLYPH_ROWS        = 5;
  localparam int GLYPH_COLS        = 4;
  localparam int GLYPH_DOTS        = GLYPH_ROWS * GLYPH_COLS;
  localparam int GLYPH_ADVANCE_DEF = 5;

  // field widths
  localparam int CHAR_W   = 8;
  localparam int COORD_W  = 16;
  localparam int ORG_W    = 12;
  localparam int SCALE_W  = 5;
  localparam int COLOR_W  = 32;
  localparam int GIDX_W   = 6;
  localparam int COL_W    = $clog2(GLYPH_COLS);
  localparam int SCALE_MAX = (1 << SCALE_W) - 1;
  localparam int XOFF_W   = $clog2((GLYPH_COLS - 1) * SCALE_MAX + 1);
  localparam int YOFF_W   = $clog2((GLYPH_ROWS - 1) * SCALE_MAX + 1);

  // APB register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_SCALE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DRAW_COLOR  = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd1;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch a new character beat
    logic step;    // move on to the next glyph dot
    logic emit;    // load the output register with the current dot
    logic finish;  // advance the cursor, character done
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bit_set;     // current dot is lit
    logic rest_empty;  // no lit dot after the current one
    logic out_free;    // output register can take a beat this cycle
  } sts_t;

  // fold lower case and map a character byte to its font slot (0 = blank)
  function automatic logic [GIDX_W-1:0] glyph_index(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] up;
    logic [GIDX_W-1:0] idx;
    up = ch;
    if (ch >= 8'd97 && ch <= 8'd122) up = ch - 8'd32;
    case (up) inside
      [8'd65:8'd90]: idx = GIDX_W'(up - 8'd64);
      [8'd48:8'd57]: idx = GIDX_W'(up - 8'd21);
      8'd46:         idx = GIDX_W'(37);
      8'd44:         idx = GIDX_W'(38);
      8'd45:         idx = GIDX_W'(39);
      8'd58:         idx = GIDX_W'(40);
      8'd33:         idx = GIDX_W'(41);
      8'd39:         idx = GIDX_W'(42);
      8'd64:         idx = GIDX_W'(43);
      default:       idx = '0;
    endcase
    return idx;
  endfunction

  // font rows packed with the top row in the low nibble, bit 3 = left column
  function automatic logic [GLYPH_DOTS-1:0] font_rows(input logic [GIDX_W-1:0] idx);
    logic [GLYPH_DOTS-1:0] rows;
    case (idx)
      6'd1:    rows = 20'h99F96;  // A
      6'd2:    rows = 20'hE9E9E;
      6'd3:    rows = 20'h78887;
      6'd4:    rows = 20'hE999E;
      6'd5:    rows = 20'hF8E8F;
      6'd6:    rows = 20'h88E8F;
      6'd7:    rows = 20'h79B87;
      6'd8:    rows = 20'h99F99;
      6'd9:    rows = 20'hE444E;
      6'd10:   rows = 20'h69113;
      6'd11:   rows = 20'h9ACA9;
      6'd12:   rows = 20'hF8888;
      6'd13:   rows = 20'h99FF9;
      6'd14:   rows = 20'h99BD9;
      6'd15:   rows = 20'h69996;
      6'd16:   rows = 20'h88E9E;
      6'd17:   rows = 20'h7B996;
      6'd18:   rows = 20'h9AE9E;
      6'd19:   rows = 20'hE1687;
      6'd20:   rows = 20'h4444F;
      6'd21:   rows = 20'h69999;
      6'd22:   rows = 20'h66999;
      6'd23:   rows = 20'h9FF99;
      6'd24:   rows = 20'h99699;
      6'd25:   rows = 20'h44699;
      6'd26:   rows = 20'hF421F;  // Z
      6'd27:   rows = 20'h69996;  // 0
      6'd28:   rows = 20'h72262;
      6'd29:   rows = 20'hF861E;
      6'd30:   rows = 20'hE161E;
      6'd31:   rows = 20'h11F99;
      6'd32:   rows = 20'hE1E8F;
      6'd33:   rows = 20'h69E87;
      6'd34:   rows = 20'h4421F;
      6'd35:   rows = 20'h69696;
      6'd36:   rows = 20'hE1796;  // 9
      6'd37:   rows = 20'h22000;  // period
      6'd38:   rows = 20'h42000;  // comma
      6'd39:   rows = 20'h00E00;  // dash
      6'd40:   rows = 20'h02020;  // colon
      6'd41:   rows = 20'h20222;  // bang
      6'd42:   rows = 20'h00022;  // apostrophe
      6'd43:   rows = 20'h78B96;  // at sign
      default: rows = '0;
    endcase
    return rows;
  endfunction

  // reorder to scan order: bit (row*COLS + col), left column first
  function automatic logic [GLYPH_DOTS-1:0] scan_bits(input logic [GLYPH_DOTS-1:0] rows);
    logic [GLYPH_DOTS-1:0] bits;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        bits[r*GLYPH_COLS + c] = rows[r*GLYPH_COLS + (GLYPH_COLS - 1 - c)];
      end
    end
    return bits;
  endfunction

endpackage

@@ rtl/glyph_rasterizer_4x5_top.sv @@
// Top level of the 4x5 bitmap font glyph rasterizer.
//
//   port group  dir      handshake        carries
//   in_*        input    in_valid/ready   one character beat
//   out_*       output   out_valid/ready  one filled square beat
//   p*          APB      psel/penable     origin_x, origin_y, pixel_scale, draw_color
//
// A character beat is loaded, then its glyph dots are scanned in order up to and
// including its last lit dot, sequenced by the controller.
// A blank glyph emits nothing.
// A lit dot waits while the output register holds an untaken beat.
// Synchronous active-low reset; cursor resets to 0, no clearing pass.
`timescale 1ns / 1ps
`include "glyph_rasterizer_4x5_top_assert.svh"
module glyph_rasterizer_4x5_top #(
  parameter int GLYPH_ADVANCE = gr4x5_pkg::GLYPH_ADVANCE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gr4x5_pkg::CHAR_W-1:0]      in_char_code,
  input  logic                              in_text_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gr4x5_pkg::COORD_W-1:0]     out_rect_x,
  output logic [gr4x5_pkg::COORD_W-1:0]     out_rect_y,
  output logic [gr4x5_pkg::SCALE_W-1:0]     out_rect_size,
  output logic [gr4x5_pkg::COLOR_W-1:0]     out_rect_color,
  output logic                              out_last_of_char,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gr4x5_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [gr4x5_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [gr4x5_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);

  logic [gr4x5_pkg::ORG_W-1:0]   cfg_origin_x;
  logic [gr4x5_pkg::ORG_W-1:0]   cfg_origin_y;
  logic [gr4x5_pkg::SCALE_W-1:0] cfg_pixel_scale;
  logic [gr4x5_pkg::COLOR_W-1:0] cfg_draw_color;
  gr4x5_pkg::cmd_t               ctrl_cmd;
  gr4x5_pkg::sts_t               dp_sts;

  gr4x5_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .origin_x    (cfg_origin_x),
    .origin_y    (cfg_origin_y),
    .pixel_scale (cfg_pixel_scale),
    .draw_color  (cfg_draw_color)
  );

  gr4x5_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (ctrl_cmd),
    .sts      (dp_sts)
  );

  gr4x5_dp #(
    .GLYPH_ADVANCE (GLYPH_ADVANCE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (ctrl_cmd),
    .sts              (dp_sts),
    .in_char_code     (in_char_code),
    .in_text_start    (in_text_start),
    .origin_x         (cfg_origin_x),
    .origin_y         (cfg_origin_y),
    .pixel_scale      (cfg_pixel_scale),
    .draw_color       (cfg_draw_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rect_x       (out_rect_x),
    .out_rect_y       (out_rect_y),
    .out_rect_size    (out_rect_size),
    .out_rect_color   (out_rect_color),
    .out_last_of_char (out_last_of_char)
  );

  // one character in flight: no second beat right after an accept
  `GR_ASSERT_NXT(a_single_char, clk, rst_n, in_valid && in_ready, !in_ready, "beat accepted while busy")
  // a square is only written into a free output register
  `GR_ASSERT_IMP(a_emit_free, clk, rst_n, ctrl_cmd.emit, dp_sts.out_free, "output beat overwritten")
  // a new output beat always comes from an emit command
  `GR_ASSERT_IMP(a_out_source, clk, rst_n, $rose(out_valid), $past(ctrl_cmd.emit), "output valid without emit")

endmodule

@@ rtl/gr4x5_regs.sv @@
// APB configuration registers of the glyph rasterizer.
`timescale 1ns / 1ps
module gr4x5_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gr4x5_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [gr4x5_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [gr4x5_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output logic [gr4x5_pkg::ORG_W-1:0]         origin_x,
  output logic [gr4x5_pkg::ORG_W-1:0]         origin_y,
  output logic [gr4x5_pkg::SCALE_W-1:0]       pixel_scale,
  output logic [gr4x5_pkg::COLOR_W-1:0]       draw_color
);

  logic [gr4x5_pkg::ORG_W-1:0]     origin_x_r;
  logic [gr4x5_pkg::ORG_W-1:0]     origin_y_r;
  logic [gr4x5_pkg::SCALE_W-1:0]   scale_r;
  logic [gr4x5_pkg::COLOR_W-1:0]   color_r;
  logic [gr4x5_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[gr4x5_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      scale_r    <= gr4x5_pkg::SCALE_RESET;
      color_r    <= gr4x5_pkg::COLOR_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        gr4x5_pkg::REG_ORIGIN_X:    origin_x_r <= pwdata[gr4x5_pkg::ORG_W-1:0];
        gr4x5_pkg::REG_ORIGIN_Y:    origin_y_r <= pwdata[gr4x5_pkg::ORG_W-1:0];
        gr4x5_pkg::REG_PIXEL_SCALE: scale_r    <= pwdata[gr4x5_pkg::SCALE_W-1:0];
        gr4x5_pkg::REG_DRAW_COLOR:  color_r    <= pwdata[gr4x5_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      gr4x5_pkg::REG_ORIGIN_X:    prdata = gr4x5_pkg::APB_DATA_W'(origin_x_r);
      gr4x5_pkg::REG_ORIGIN_Y:    prdata = gr4x5_pkg::APB_DATA_W'(origin_y_r);
      gr4x5_pkg::REG_PIXEL_SCALE: prdata = gr4x5_pkg::APB_DATA_W'(scale_r);
      gr4x5_pkg::REG_DRAW_COLOR:  prdata = gr4x5_pkg::APB_DATA_W'(color_r);
      default:                    prdata = '0;
    endcase
  end

  assign origin_x    = origin_x_r;
  assign origin_y    = origin_y_r;
  assign pixel_scale = scale_r;
  assign draw_color  = color_r;

endmodule

@@ rtl/gr4x5_ctrl.sv @@
// Controller FSM: accepts a character and walks its glyph dots.
`timescale 1ns / 1ps
module gr4x5_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output gr4x5_pkg::cmd_t   cmd,
  input  gr4x5_pkg::sts_t   sts
);

  gr4x5_pkg::state_t state_r;
  gr4x5_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gr4x5_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gr4x5_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = gr4x5_pkg::ST_SCAN;
        end
      end
      gr4x5_pkg::ST_SCAN: begin
        // a lit dot waits for room in the output register
        if (!sts.bit_set || sts.out_free) begin
          cmd.step = 1'b1;
          cmd.emit = sts.bit_set;
          if (sts.rest_empty) begin
            cmd.finish = 1'b1;
            state_nxt  = gr4x5_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = gr4x5_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/gr4x5_dp.sv @@
// Datapath: glyph shift register, dot offsets, cursor and output register.
`timescale 1ns / 1ps
module gr4x5_dp #(
  parameter int GLYPH_ADVANCE = gr4x5_pkg::GLYPH_ADVANCE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gr4x5_pkg::cmd_t                   cmd,
  output gr4x5_pkg::sts_t                   sts,
  input  logic [gr4x5_pkg::CHAR_W-1:0]      in_char_code,
  input  logic                              in_text_start,
  input  logic [gr4x5_pkg::ORG_W-1:0]       origin_x,
  input  logic [gr4x5_pkg::ORG_W-1:0]       origin_y,
  input  logic [gr4x5_pkg::SCALE_W-1:0]     pixel_scale,
  input  logic [gr4x5_pkg::COLOR_W-1:0]     draw_color,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gr4x5_pkg::COORD_W-1:0]     out_rect_x,
  output logic [gr4x5_pkg::COORD_W-1:0]     out_rect_y,
  output logic [gr4x5_pkg::SCALE_W-1:0]     out_rect_size,
  output logic [gr4x5_pkg::COLOR_W-1:0]     out_rect_color,
  output logic                              out_last_of_char
);

  localparam int ADV_W  = $clog2(GLYPH_ADVANCE + 1);
  localparam int PROD_W = gr4x5_pkg::SCALE_W + ADV_W;
  localparam int SUM_W  = gr4x5_pkg::COORD_W + 1;

  logic [gr4x5_pkg::GLYPH_DOTS-1:0] glyph_r;
  logic [gr4x5_pkg::COL_W-1:0]      col_r;
  logic [gr4x5_pkg::XOFF_W-1:0]     xoff_r;
  logic [gr4x5_pkg::YOFF_W-1:0]     yoff_r;
  logic [gr4x5_pkg::COORD_W-1:0]    cursor_r;
  logic                             out_valid_r;
  logic [gr4x5_pkg::COORD_W-1:0]    out_x_r;
  logic [gr4x5_pkg::COORD_W-1:0]    out_y_r;
  logic [gr4x5_pkg::SCALE_W-1:0]    out_size_r;
  logic [gr4x5_pkg::COLOR_W-1:0]    out_color_r;
  logic                             out_last_r;

  logic [SUM_W-1:0]                 x_sum;
  logic [gr4x5_pkg::COORD_W-1:0]    dot_x;
  logic [gr4x5_pkg::COORD_W-1:0]    dot_y;
  logic [PROD_W-1:0]                adv_len;
  logic [SUM_W-1:0]                 cur_sum;

  // status back to the controller
  assign sts.bit_set    = glyph_r[0];
  assign sts.rest_empty = (glyph_r[gr4x5_pkg::GLYPH_DOTS-1:1] == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  // dot coordinates, x saturates
  assign x_sum = {1'b0, cursor_r} + SUM_W'(xoff_r);
  assign dot_x = x_sum[SUM_W-1] ? '1 : x_sum[gr4x5_pkg::COORD_W-1:0];
  assign dot_y = gr4x5_pkg::COORD_W'(origin_y) + gr4x5_pkg::COORD_W'(yoff_r);

  // cursor advance, saturating
  assign adv_len = PROD_W'(pixel_scale) * PROD_W'(GLYPH_ADVANCE);
  assign cur_sum = {1'b0, cursor_r} + SUM_W'(adv_len);

  // glyph bits and dot offsets
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph_r <= gr4x5_pkg::scan_bits(
                   gr4x5_pkg::font_rows(gr4x5_pkg::glyph_index(in_char_code)));
      col_r   <= '0;
      xoff_r  <= '0;
      yoff_r  <= '0;
    end else if (cmd.step) begin
      glyph_r <= glyph_r >> 1;
      if (col_r == gr4x5_pkg::COL_W'(gr4x5_pkg::GLYPH_COLS - 1)) begin
        col_r  <= '0;
        xoff_r <= '0;
        yoff_r <= yoff_r + gr4x5_pkg::YOFF_W'(pixel_scale);
      end else begin
        col_r  <= col_r + 1'b1;
        xoff_r <= xoff_r + gr4x5_pkg::XOFF_W'(pixel_scale);
      end
    end
  end

  // text cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (cmd.load && in_text_start) begin
      cursor_r <= gr4x5_pkg::COORD_W'(origin_x);
    end else if (cmd.finish) begin
      cursor_r <= cur_sum[SUM_W-1] ? '1 : cur_sum[gr4x5_pkg::COORD_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r     <= dot_x;
      out_y_r     <= dot_y;
      out_size_r  <= pixel_scale;
      out_color_r <= draw_color;
      out_last_r  <= sts.rest_empty;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rect_x       = out_x_r;
  assign out_rect_y       = out_y_r;
  assign out_rect_size    = out_size_r;
  assign out_rect_color   = out_color_r;
  assign out_last_of_char = out_last_r;

endmodule
